FILE: hdl/ctrp_pkg.sv
// Shared codes, widths and types for the card track response parser.
`default_nettype none

package ctrp_pkg;

    localparam int DEF_MAX_TRACK_BYTES = 128;
    localparam int BYTE_INDEX_W        = 7;

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Characters of the reply framing.
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_END  = 8'h3F;
    localparam logic [7:0] CH_FS   = 8'h1C;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // Parser phases.
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_HDR0  = 4'd1;
    localparam logic [3:0] PH_HDR1  = 4'd2;
    localparam logic [3:0] PH_TUP0  = 4'd3;
    localparam logic [3:0] PH_TUP1  = 4'd4;
    localparam logic [3:0] PH_TRACK = 4'd5;
    localparam logic [3:0] PH_EMPTY = 4'd6;
    localparam logic [3:0] PH_STAT0 = 4'd7;
    localparam logic [3:0] PH_STAT1 = 4'd8;

    // Result status codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_OK   = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    // Error kinds.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_HEADER   = 3'd1;
    localparam logic [2:0] ERR_TUPLE    = 3'd2;
    localparam logic [2:0] ERR_EMPTY    = 3'd3;
    localparam logic [2:0] ERR_STATUS   = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW = 3'd5;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]              status;
        logic [2:0]              error_kind;
        logic                    data_valid;
        logic [1:0]              track_number;
        logic [BYTE_INDEX_W-1:0] byte_index;
        logic [7:0]              data_byte;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/ctrp_in_stage.sv
// Input register stage: captures one transaction and holds it while downstream stalls.
`default_nettype none

module ctrp_in_stage
    import ctrp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_stall,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // The register holds while its item is waiting and cannot move on.
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: hdl/ctrp_parser.sv
// Deframing state machine: parser state and the result of each byte.
`default_nettype none

module ctrp_parser
    import ctrp_pkg::*;
#(
    parameter int MAX_TRACK_BYTES = DEF_MAX_TRACK_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    output t_result    o_result
);

    localparam int FW = $clog2(MAX_TRACK_BYTES + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_TRACK_BYTES);

    logic [3:0]    r_phase,   n_phase;
    logic [7:0]    r_held,    n_held;
    logic [1:0]    r_track,   n_track;
    logic [FW-1:0] r_fill,    n_fill;
    t_result       n_result;

    logic [FW+BYTE_INDEX_W-1:0] w_fill_ext;
    logic [7:0]                 w_b;

    assign w_fill_ext = {{BYTE_INDEX_W{1'b0}}, r_fill};
    assign w_b        = i_item.rx_byte;

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_track  = r_track;
        n_fill   = r_fill;
        n_result = '0;
        n_result.status = ST_BUSY;

        if (i_item.op == OP_START) begin
            n_phase = PH_HDR0;
            n_held  = '0;
            n_track = '0;
            n_fill  = '0;
        end else begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_held  = w_b;
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    if (r_held != CH_ESC || w_b != CH_S) begin
                        n_phase             = PH_IDLE;
                        n_result.status     = ST_ERR;
                        n_result.error_kind = ERR_HEADER;
                    end else begin
                        n_phase = PH_TUP0;
                    end
                end
                PH_TUP0: begin
                    n_held  = w_b;
                    n_phase = PH_TUP1;
                end
                PH_TUP1: begin
                    if (r_held == CH_ESC && w_b >= 8'd1 && w_b <= 8'd3) begin
                        n_track = w_b[1:0];
                        n_fill  = '0;
                        n_phase = PH_TRACK;
                    end else if (r_held == CH_END && w_b == CH_FS) begin
                        n_phase = PH_STAT0;
                    end else begin
                        n_phase             = PH_IDLE;
                        n_result.status     = ST_ERR;
                        n_result.error_kind = ERR_TUPLE;
                    end
                end
                PH_TRACK: begin
                    if (w_b == CH_ESC) begin
                        n_phase = PH_EMPTY;
                    end else if (r_fill >= FILL_MAX) begin
                        n_phase             = PH_IDLE;
                        n_result.status     = ST_ERR;
                        n_result.error_kind = ERR_OVERFLOW;
                    end else begin
                        n_fill                = r_fill + 1'b1;
                        n_result.data_valid   = 1'b1;
                        n_result.track_number = r_track;
                        n_result.byte_index   = w_fill_ext[BYTE_INDEX_W-1:0];
                        n_result.data_byte    = w_b;
                        if (w_b == CH_END) begin
                            n_phase = PH_TUP0;
                        end
                    end
                end
                PH_EMPTY: begin
                    if (w_b != CH_STAR) begin
                        n_phase             = PH_IDLE;
                        n_result.status     = ST_ERR;
                        n_result.error_kind = ERR_EMPTY;
                    end else begin
                        n_phase = PH_TUP0;
                    end
                end
                PH_STAT0: begin
                    n_held  = w_b;
                    n_phase = PH_STAT1;
                end
                PH_STAT1: begin
                    n_phase = PH_IDLE;
                    if (r_held != CH_ESC || w_b != CH_ZERO) begin
                        n_result.status     = ST_ERR;
                        n_result.error_kind = ERR_STATUS;
                    end else begin
                        n_result.status = ST_OK;
                    end
                end
                default: begin
                    n_phase         = PH_IDLE;
                    n_result.status = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
            r_track <= '0;
            r_fill  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_track <= n_track;
            r_fill  <= n_fill;
        end
    end

    assign o_result = n_result;

endmodule

`default_nettype wire

FILE: hdl/ctrp_out_stage.sv
// Result register stage: holds one result transaction until the consumer takes it.
`default_nettype none

module ctrp_out_stage
    import ctrp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held result leaves in this cycle.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: hdl/card_track_response_parser.sv
// Top level of the card track response parser: input register, parser, result register.
`default_nettype none

//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_op, i_rx_byte
//  result    out        o_valid / i_stall    o_status, o_error_kind, o_data_valid,
//                                            o_track_number, o_byte_index, o_data_byte
//
// Every input transaction yields exactly one result transaction, which passes first
// through the input register and then through the result register.
// The parser state changes when an item moves from the input register into the
// result register, so with no stall one item per cycle passes through that single step.
// Synchronous active-low reset empties both registers and returns the parser to idle.
// A stall on the result side holds the result register; the input register then
// fills, and only after that is o_stall raised toward the sender.

module card_track_response_parser
    import ctrp_pkg::*;
#(
    parameter int MAX_TRACK_BYTES = DEF_MAX_TRACK_BYTES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_op,
    input  wire logic [7:0]              i_rx_byte,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [1:0]                   o_status,
    output logic [2:0]                   o_error_kind,
    output logic                         o_data_valid,
    output logic [1:0]                   o_track_number,
    output logic [BYTE_INDEX_W-1:0]      o_byte_index,
    output logic [7:0]                   o_data_byte
);

    t_item   w_in_item;
    t_item   w_held_item;
    logic    w_held_valid;
    logic    w_out_ready;
    logic    w_fire;
    t_result w_next_result;
    t_result w_result;

    assign w_in_item.op      = i_op;
    assign w_in_item.rx_byte = i_rx_byte;

    // An item is processed in the cycle it moves into the result register.
    assign w_fire = w_held_valid && w_out_ready;

    ctrp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (w_in_item),
        .o_stall (o_stall),
        .i_take  (w_out_ready),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    ctrp_parser #(
        .MAX_TRACK_BYTES (MAX_TRACK_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_held_item),
        .o_result (w_next_result)
    );

    ctrp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_held_valid),
        .i_result (w_next_result),
        .o_ready  (w_out_ready),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (w_result)
    );

    assign o_status       = w_result.status;
    assign o_error_kind   = w_result.error_kind;
    assign o_data_valid   = w_result.data_valid;
    assign o_track_number = w_result.track_number;
    assign o_byte_index   = w_result.byte_index;
    assign o_data_byte    = w_result.data_byte;

endmodule

`default_nettype wire

FILE: tb/card_track_response_parser_test.sv
// Self-checking testbench for the card track response parser.
`timescale 1ns / 100ps

module card_track_response_parser_test;
    import ctrp_pkg::*;

    localparam int MAX_TRACK_BYTES = DEF_MAX_TRACK_BYTES;
    // Sending stops once about this many transactions have been accepted in all.
    localparam int RANDOM_ITEMS    = 800;
    // Pipeline depth is two, and the receiver may hold a result for a while.
    localparam int DRAIN_CYCLES    = 40;
    // Marks whether a directed row carries a result written out by hand.
    localparam bit LISTED          = 1'b1;
    localparam bit PREDICTED       = 1'b0;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic       listed;
        logic [1:0] status;
        logic [2:0] error_kind;
    } t_directed_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_op;
    logic [7:0]              i_rx_byte;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [1:0]              o_status;
    logic [2:0]              o_error_kind;
    logic                    o_data_valid;
    logic [1:0]              o_track_number;
    logic [BYTE_INDEX_W-1:0] o_byte_index;
    logic [7:0]              o_data_byte;

    // Shadow copy of the parser state, advanced once per accepted transaction.
    logic [3:0] parse_phase;
    logic [7:0] pair_first;
    logic [1:0] open_track;
    logic [8:0] track_fill;

    // Results that the parser still owes us, oldest first.
    t_result outstanding_parse_results[$];
    // The reply currently being fed to the parser.
    t_item   reply_items[$];

    int burst_left;
    int counted_bytes;
    int mismatch_count;

    // Receiver stall pattern, rotated once per cycle and reloaded now and then.
    logic [15:0] stall_pattern = 16'h0000;
    int          stall_hold    = 0;

    // The directed part walks this list. Rows with an obvious outcome (ignored bytes, a
    // clean finish, each error but overflow) carry a result; the rest are predicted.
    t_directed_row directed_rows [0:42] = '{
        // A byte right after reset reaches an idle parser and is ignored.
        '{OP_BYTE,  8'hFF,   LISTED,    ST_IDLE, ERR_NONE},
        // A complete reply: header, track 3 with extreme bytes, track 3 reopened
        // with one byte and closed through the empty marker, end block and good status.
        '{OP_START, 8'hA5,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_S,    PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  8'h03,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  8'h00,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  8'hFF,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_END,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  8'h03,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  8'h7F,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_STAR, PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_END,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_FS,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ZERO, LISTED,    ST_OK,   ERR_NONE},
        // After a finished parse the parser is idle again.
        '{OP_BYTE,  8'h55,   LISTED,    ST_IDLE, ERR_NONE},
        // A start in the middle of the header restarts the parse; then a bad header.
        '{OP_START, 8'h00,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_START, 8'hFF,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  8'h00,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_S,    LISTED,    ST_ERR,  ERR_HEADER},
        // An escape followed by a track number below the legal range.
        '{OP_START, 8'h5A,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_S,    PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  8'h00,   LISTED,    ST_ERR,  ERR_TUPLE},
        // An escape inside a track that is not followed by the empty marker.
        '{OP_START, 8'h00,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_S,    PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  8'h01,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  8'h00,   LISTED,    ST_ERR,  ERR_EMPTY},
        // An end block whose status pair is not the success code.
        '{OP_START, 8'h00,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_S,    PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_END,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_FS,   PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  CH_ESC,  PREDICTED, ST_BUSY, ERR_NONE},
        '{OP_BYTE,  8'h31,   LISTED,    ST_ERR,  ERR_STATUS}
    };

    card_track_response_parser #(
        .MAX_TRACK_BYTES(MAX_TRACK_BYTES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_error_kind  (o_error_kind),
        .o_data_valid  (o_data_valid),
        .o_track_number(o_track_number),
        .o_byte_index  (o_byte_index),
        .o_data_byte   (o_data_byte)
    );

    // 20 ns period clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Any failed pair check ends the parse and drops the parser back to idle.
    function automatic t_result abort_parse(logic [2:0] kind);
        t_result r;
        r            = '0;
        r.status     = ST_ERR;
        r.error_kind = kind;
        parse_phase  = PH_IDLE;
        return r;
    endfunction

    // Advances the shadow state by one transaction and returns the result it causes.
    function automatic t_result deframe_byte(t_item it);
        t_result r;
        r        = '0;
        r.status = ST_BUSY;
        if (it.op == OP_START) begin
            parse_phase = PH_HDR0;
            pair_first  = '0;
            open_track  = '0;
            track_fill  = '0;
            return r;
        end
        case (parse_phase)
            PH_HDR0: begin
                pair_first  = it.rx_byte;
                parse_phase = PH_HDR1;
            end
            PH_HDR1: begin
                if (pair_first != CH_ESC || it.rx_byte != CH_S)
                    r = abort_parse(ERR_HEADER);
                else
                    parse_phase = PH_TUP0;
            end
            PH_TUP0: begin
                pair_first  = it.rx_byte;
                parse_phase = PH_TUP1;
            end
            PH_TUP1: begin
                if (pair_first == CH_ESC && it.rx_byte >= 8'd1 && it.rx_byte <= 8'd3) begin
                    open_track  = it.rx_byte[1:0];
                    track_fill  = '0;
                    parse_phase = PH_TRACK;
                end else if (pair_first == CH_END && it.rx_byte == CH_FS) begin
                    parse_phase = PH_STAT0;
                end else begin
                    r = abort_parse(ERR_TUPLE);
                end
            end
            PH_TRACK: begin
                if (it.rx_byte == CH_ESC) begin
                    parse_phase = PH_EMPTY;
                end else if (track_fill >= MAX_TRACK_BYTES) begin
                    // The buffer is full, so this byte cannot be stored.
                    r = abort_parse(ERR_OVERFLOW);
                end else begin
                    r.data_valid   = 1'b1;
                    r.track_number = open_track;
                    r.byte_index   = track_fill[BYTE_INDEX_W-1:0];
                    r.data_byte    = it.rx_byte;
                    track_fill     = track_fill + 9'd1;
                    if (it.rx_byte == CH_END)
                        parse_phase = PH_TUP0;
                end
            end
            PH_EMPTY: begin
                if (it.rx_byte != CH_STAR)
                    r = abort_parse(ERR_EMPTY);
                else
                    parse_phase = PH_TUP0;
            end
            PH_STAT0: begin
                pair_first  = it.rx_byte;
                parse_phase = PH_STAT1;
            end
            PH_STAT1: begin
                if (pair_first != CH_ESC || it.rx_byte != CH_ZERO) begin
                    r = abort_parse(ERR_STATUS);
                end else begin
                    parse_phase = PH_IDLE;
                    r.status    = ST_OK;
                end
            end
            default: begin
                // Bytes that reach an idle parser are dropped.
                parse_phase = PH_IDLE;
                r           = '0;
            end
        endcase
        return r;
    endfunction

    // Offers one transaction to the parser and books its result once it is taken.
    // The sender works in bursts; between bursts valid drops for a random gap.
    task automatic send_item(input t_item it, input logic listed, input t_result listed_result);
        t_result predicted;
        int      gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid   <= 1'b0;
                i_op      <= 1'($urandom);
                i_rx_byte <= 8'($urandom);
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 150 : 12);
        end
        burst_left = burst_left - 1;
        i_valid   <= 1'b1;
        i_op      <= it.op;
        i_rx_byte <= it.rx_byte;
        // The payload stays put until an edge sees the stall low.
        do @(posedge i_clk); while (o_stall);
        predicted = deframe_byte(it);
        outstanding_parse_results.push_back(listed ? listed_result : predicted);
        counted_bytes = counted_bytes + 1;
    endtask

    task automatic add_item(input logic op, input logic [7:0] b);
        t_item it;
        it.op      = op;
        it.rx_byte = b;
        reply_items.push_back(it);
    endtask

    // A track byte that neither closes the track nor escapes out of it.
    function automatic logic [7:0] plain_track_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_ESC || b == CH_END);
        return b;
    endfunction

    // Builds a well-formed reply with random content. A non-negative forced_len
    // gives a single track of exactly that many plain bytes, closed by the sentinel.
    task automatic build_reply(input int forced_len);
        int tuples;
        int len;
        reply_items.delete();
        add_item(OP_START, 8'($urandom));
        add_item(OP_BYTE, CH_ESC);
        add_item(OP_BYTE, CH_S);
        tuples = (forced_len >= 0) ? 1 : $urandom_range(0, 4);
        for (int t = 0; t < tuples; t++) begin
            add_item(OP_BYTE, CH_ESC);
            add_item(OP_BYTE, 8'($urandom_range(1, 3)));
            if (forced_len >= 0)
                len = forced_len;
            else if ($urandom_range(0, 15) == 0)
                len = $urandom_range(MAX_TRACK_BYTES - 8, MAX_TRACK_BYTES + 3);
            else
                len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++)
                add_item(OP_BYTE, plain_track_byte());
            // Now and then the track is closed through the empty marker instead.
            if (forced_len < 0 && $urandom_range(0, 4) == 0) begin
                add_item(OP_BYTE, CH_ESC);
                add_item(OP_BYTE, CH_STAR);
            end else begin
                add_item(OP_BYTE, CH_END);
            end
        end
        add_item(OP_BYTE, CH_END);
        add_item(OP_BYTE, CH_FS);
        add_item(OP_BYTE, CH_ESC);
        add_item(OP_BYTE, CH_ZERO);
    endtask

    task automatic send_reply();
        t_result none;
        none = '0;
        foreach (reply_items[i])
            send_item(reply_items[i], PREDICTED, none);
    endtask

    // The receiver stalls on a rotating pattern that is reloaded every so often:
    // no stall at all, random, long holds, sparse periodic, or almost constant stall.
    always @(negedge i_clk) begin
        if (stall_hold == 0) begin
            case ($urandom_range(0, 4))
                0:       stall_pattern = 16'h0000;
                1:       stall_pattern = 16'($urandom);
                2:       stall_pattern = 16'hFF00;
                3:       stall_pattern = 16'h8888;
                default: stall_pattern = 16'hFFFE;
            endcase
            stall_hold = $urandom_range(20, 120);
        end else begin
            stall_hold = stall_hold - 1;
        end
        i_stall       <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    // Every result transaction is matched against the oldest booked result.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (outstanding_parse_results.size() == 0) begin
                $error("result transaction arrived with no result outstanding");
                mismatch_count = mismatch_count + 1;
            end else begin
                want = outstanding_parse_results.pop_front();
                compare_field("status", 32'(want.status), 32'(o_status));
                compare_field("error_kind", 32'(want.error_kind), 32'(o_error_kind));
                compare_field("data_valid", 32'(want.data_valid), 32'(o_data_valid));
                compare_field("track_number", 32'(want.track_number),
                              32'(o_track_number));
                compare_field("byte_index", 32'(want.byte_index), 32'(o_byte_index));
                compare_field("data_byte", 32'(want.data_byte), 32'(o_data_byte));
            end
        end
    end

    // Main sequence: reset, directed list, the two longest tracks, then random replies.
    initial begin
        t_item   it;
        t_result listed_result;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_op           = OP_BYTE;
        i_rx_byte      = 8'h00;
        burst_left     = 0;
        counted_bytes  = 0;
        mismatch_count = 0;
        parse_phase    = PH_IDLE;
        pair_first     = '0;
        open_track     = '0;
        track_fill     = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            it.op                    = directed_rows[i].op;
            it.rx_byte               = directed_rows[i].rx_byte;
            listed_result            = '0;
            listed_result.status     = directed_rows[i].status;
            listed_result.error_kind = directed_rows[i].error_kind;
            send_item(it, directed_rows[i].listed, listed_result);
        end

        // The longest track that fits ends with its sentinel at the last index.
        build_reply(MAX_TRACK_BYTES - 1);
        send_reply();
        // One byte more and the sentinel itself overflows the buffer.
        build_reply(MAX_TRACK_BYTES);
        send_reply();

        // Mostly well-formed replies, some with one byte spoiled or a restart
        // dropped in; the rest is line noise, much of which hits an idle parser.
        while (counted_bytes < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
                int spot;
                build_reply(-1);
                if ($urandom_range(0, 2) == 0) begin
                    spot = $urandom_range(1, reply_items.size() - 1);
                    if ($urandom_range(0, 9) == 0)
                        reply_items[spot].op = OP_START;
                    else
                        reply_items[spot].rx_byte = 8'($urandom);
                end
            end else begin
                reply_items.delete();
                repeat ($urandom_range(1, 8))
                    add_item(($urandom_range(0, 4) == 0) ? OP_START : OP_BYTE,
                             8'($urandom));
            end
            send_reply();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        while (outstanding_parse_results.size() != 0) @(posedge i_clk);
        // Give a stray extra result the chance to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hdl/ctrp_pkg.sv
hdl/ctrp_in_stage.sv
hdl/ctrp_parser.sv
hdl/ctrp_out_stage.sv
hdl/card_track_response_parser.sv
tb/card_track_response_parser_test.sv
